FILE: rtl/env_sensor_temp_hum_compensation_macros.svh
// ----------------------------------------------------------------------------
// env_sensor_temp_hum_compensation_macros.svh
// Assertion macros shared by the checkers of the compensation block.
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_TEMP_HUM_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_TEMP_HUM_COMPENSATION_MACROS_SVH

// same-cycle implication
`define ESTHC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("esthc assertion failed: same-cycle rule");

// next-cycle implication
`define ESTHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("esthc assertion failed: next-cycle rule");

`endif

FILE: rtl/esthc_pkg.sv
// ----------------------------------------------------------------------------
// esthc_pkg
// Types, widths, register indexes and helpers of the compensation block.
// ----------------------------------------------------------------------------
package esthc_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned ADC_TEMP_W   = 20;
	localparam int unsigned ADC_HUM_W    = 16;
	localparam int unsigned TEMP_CENTI_W = 24;
	localparam int unsigned HUM_Q10_W    = 17;
	localparam int unsigned T_FINE_W     = 32;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 16;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_TEMP_CAL_1  = 3'd0;
	localparam cfg_idx_t REG_TEMP_CAL_2  = 3'd1;
	localparam cfg_idx_t REG_TEMP_CAL_3  = 3'd2;
	localparam cfg_idx_t REG_HUM_CAL_1   = 3'd3;
	localparam cfg_idx_t REG_HUM_CAL_2   = 3'd4;
	localparam cfg_idx_t REG_HUM_CAL_3   = 3'd5;
	localparam cfg_idx_t REG_HUM_CAL_4_5 = 3'd6;
	localparam cfg_idx_t REG_HUM_CAL_6   = 3'd7;

	localparam word_t T_FINE_OFS = 32'd76800;
	localparam word_t HUM_FULL   = 32'd419430400;
	localparam word_t ROUND_X    = 32'd16384;
	localparam word_t Q_OFS      = 32'd32768;
	localparam word_t R_OFS      = 32'd2097152;
	localparam word_t ROUND_Y    = 32'd8192;
	localparam word_t ROUND_T    = 32'd128;

	function automatic word_t asr(input word_t x, input int unsigned n);
		return word_t'($signed(x) >>> n);
	endfunction

	function automatic word_t sext8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic word_t sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

FILE: rtl/esthc_if.sv
// ----------------------------------------------------------------------------
// esthc_if
// Ready/valid channels of the compensation block: raw readings in,
// compensated values out.
// ----------------------------------------------------------------------------
interface esthc_in_if;
	import esthc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ADC_TEMP_W-1:0] adc_temp;
	logic [ADC_HUM_W-1:0]  adc_hum;

	modport source (output valid, output adc_temp, output adc_hum, input ready);
	modport sink   (input valid, input adc_temp, input adc_hum, output ready);
endinterface

interface esthc_out_if;
	import esthc_pkg::*;

	logic                           valid;
	logic                           ready;
	logic signed [TEMP_CENTI_W-1:0] temp_centi;
	logic [HUM_Q10_W-1:0]           hum_q10;
	logic signed [T_FINE_W-1:0]     t_fine_out;

	modport source (output valid, output temp_centi, output hum_q10, output t_fine_out,
		input ready);
	modport sink   (input valid, input temp_centi, input hum_q10, input t_fine_out,
		output ready);
endinterface

FILE: rtl/env_sensor_temp_hum_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_temp_hum_compensation
// Integer temperature and humidity compensation of a combined sensor.
// ----------------------------------------------------------------------------
// Ten-stage pipeline, at most one multiplier level per stage: one reading pair
// is taken every cycle unless the pipeline stalls; the beat lands in the first
// stage and its result is presented from the last. The depth is set by the
// chain of eight dependent 32-bit multiplies (fine temperature, then the
// humidity product terms) plus the fine temperature sum and the final clamp.
// Each stage holds while the one after it is full and stalled, so a stall on
// the result side holds only as much of the pipeline as needed; the last
// stage is the output register.
// User must write calibration via cfg while no beat is in flight (unchecked).
// ----------------------------------------------------------------------------
module env_sensor_temp_hum_compensation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  esthc_pkg::cfg_idx_t  cfg_idx,
	input  esthc_pkg::cfg_data_t cfg_data,
	esthc_in_if.sink             sample,
	esthc_out_if.source          result
);
	import esthc_pkg::*;

	localparam int unsigned NSTG = 10;

	logic [15:0] temp_cal_1_q, temp_cal_2_q, hum_cal_4_5_q;
	logic [7:0]  temp_cal_3_q, hum_cal_1_q, hum_cal_3_q, hum_cal_6_q;
	logic [11:0] hum_cal_2_q;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_1_q  <= '0;
			temp_cal_2_q  <= '0;
			temp_cal_3_q  <= '0;
			hum_cal_1_q   <= '0;
			hum_cal_2_q   <= '0;
			hum_cal_3_q   <= '0;
			hum_cal_4_5_q <= '0;
			hum_cal_6_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TEMP_CAL_1:  temp_cal_1_q  <= cfg_data;
				REG_TEMP_CAL_2:  temp_cal_2_q  <= cfg_data;
				REG_TEMP_CAL_3:  temp_cal_3_q  <= cfg_data[7:0];
				REG_HUM_CAL_1:   hum_cal_1_q   <= cfg_data[7:0];
				REG_HUM_CAL_2:   hum_cal_2_q   <= cfg_data[11:0];
				REG_HUM_CAL_3:   hum_cal_3_q   <= cfg_data[7:0];
				REG_HUM_CAL_4_5: hum_cal_4_5_q <= cfg_data;
				REG_HUM_CAL_6:   hum_cal_6_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// calibration as 32-bit patterns
	word_t t1, t2, t3, h1, h2, h3, h4, h5, h6;
	assign t1 = {16'd0, temp_cal_1_q};
	assign t2 = sext16(temp_cal_2_q);
	assign t3 = {24'd0, temp_cal_3_q};
	assign h1 = {24'd0, hum_cal_1_q};
	assign h2 = {20'd0, hum_cal_2_q};
	assign h3 = sext8(hum_cal_3_q);
	assign h4 = sext8(hum_cal_4_5_q[7:0]);
	assign h5 = sext8(hum_cal_4_5_q[15:8]);
	assign h6 = {24'd0, hum_cal_6_q};

	// stall chain
	always_comb begin
		en[NSTG] = !vld_q[NSTG] || result.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign sample.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= sample.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage datapath
	word_t                 at2_s1, bb_s1;
	logic [ADC_HUM_W-1:0]  ah_s1, ah_s2, ah_s3;
	word_t                 v1_s2, m_s2;
	word_t                 tf_s3, tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9, tf_s10;
	logic [23:0]           tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	word_t                 x_s4, x_s5, x_s6;
	word_t                 p6_s4, q3_s4;
	word_t                 pq_s5;
	word_t                 y_s6;
	word_t                 hv_s7, hv_s8, hv_s9;
	word_t                 ss_s8;
	word_t                 w_s9;
	logic [HUM_Q10_W-1:0]  hq_s10;

	word_t a_c, b_c, v_c, tc5_c, xs_c, r_c, s_c, hv_c, hq_c;

	always_comb begin
		a_c   = {15'd0, sample.adc_temp[19:3]} - {t1[30:0], 1'b0};
		b_c   = {16'd0, sample.adc_temp[19:4]} - t1;
		v_c   = tf_s3 - T_FINE_OFS;
		tc5_c = tf_s3 + {tf_s3[29:0], 2'b00} + ROUND_T;
		xs_c  = {2'd0, ah_s3, 14'd0} - {h4[11:0], 20'd0} - h5 * v_c + ROUND_X;
		r_c   = asr(pq_s5, 10) + R_OFS;
		s_c   = asr(hv_s7, 15);
		hv_c  = hv_s9 - asr(w_s9, 4);
		if (hv_c[31])
			hq_c = '0;
		else if (hv_c > HUM_FULL)
			hq_c = HUM_FULL;
		else
			hq_c = hv_c;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			at2_s1 <= a_c * t2;
			bb_s1  <= b_c * b_c;
			ah_s1  <= sample.adc_hum;
		end
		if (en[2]) begin
			v1_s2 <= asr(at2_s1, 11);
			m_s2  <= asr(bb_s1, 12) * t3;
			ah_s2 <= ah_s1;
		end
		if (en[3]) begin
			tf_s3 <= v1_s2 + asr(m_s2, 14);
			ah_s3 <= ah_s2;
		end
		if (en[4]) begin
			tf_s4 <= tf_s3;
			tc_s4 <= tc5_c[31:8];
			x_s4  <= asr(xs_c, 15);
			p6_s4 <= v_c * h6;
			q3_s4 <= v_c * h3;
		end
		if (en[5]) begin
			tf_s5 <= tf_s4;
			tc_s5 <= tc_s4;
			x_s5  <= x_s4;
			pq_s5 <= asr(p6_s4, 10) * (asr(q3_s4, 11) + Q_OFS);
		end
		if (en[6]) begin
			tf_s6 <= tf_s5;
			tc_s6 <= tc_s5;
			x_s6  <= x_s5;
			y_s6  <= asr(r_c * h2 + ROUND_Y, 14);
		end
		if (en[7]) begin
			tf_s7 <= tf_s6;
			tc_s7 <= tc_s6;
			hv_s7 <= x_s6 * y_s6;
		end
		if (en[8]) begin
			tf_s8 <= tf_s7;
			tc_s8 <= tc_s7;
			hv_s8 <= hv_s7;
			ss_s8 <= s_c * s_c;
		end
		if (en[9]) begin
			tf_s9 <= tf_s8;
			tc_s9 <= tc_s8;
			hv_s9 <= hv_s8;
			w_s9  <= asr(ss_s8, 7) * h1;
		end
		if (en[10]) begin
			tf_s10 <= tf_s9;
			tc_s10 <= tc_s9;
			hq_s10 <= hq_c[28:12];
		end
	end

	assign result.valid      = vld_q[NSTG];
	assign result.temp_centi = tc_s10;
	assign result.hum_q10    = hq_s10;
	assign result.t_fine_out = tf_s10;

endmodule

FILE: rtl/esthc_checker.sv
// ----------------------------------------------------------------------------
// esthc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "env_sensor_temp_hum_compensation_macros.svh"

module esthc_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [esthc_pkg::TEMP_CENTI_W-1:0] temp_centi,
	input logic [esthc_pkg::HUM_Q10_W-1:0]        hum_q10,
	input logic signed [esthc_pkg::T_FINE_W-1:0]  t_fine_out
);
	import esthc_pkg::*;

	word_t tc5;
	assign tc5 = word_t'(t_fine_out) + {t_fine_out[29:0], 2'b00} + ROUND_T;

	// held result beat keeps its payload
	`ESTHC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(temp_centi) && $stable(hum_q10) && $stable(t_fine_out))
	// humidity never exceeds full scale
	`ESTHC_ASSERT_IMPL(a_hum_range, out_valid, hum_q10 <= 17'd102400)
	// temperature output follows the fine temperature of the same beat
	`ESTHC_ASSERT_IMPL(a_temp_match, out_valid, temp_centi == tc5[31:8])

endmodule

bind env_sensor_temp_hum_compensation esthc_checker u_esthc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.temp_centi (result.temp_centi),
	.hum_q10    (result.hum_q10),
	.t_fine_out (result.t_fine_out)
);
